### rtl/assert_macros.svh
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define RGWE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checks that a condition in one cycle is followed by a consequence in the next.
`define RGWE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
    else $error(msg);

`endif

### rtl/rgwe_pkg.sv
// Types and constants shared by the gap write encoder modules.
package rgwe_pkg;

  // Input mode codes.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_START_GAP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_GAP = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LEN   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LEN  = 8'd3;

  // Configuration reset values.
  localparam logic [7:0] RST_START_GAP = 8'd40;
  localparam logic [7:0] RST_WRITE_GAP = 8'd19;
  localparam logic [7:0] RST_ONE_LEN   = 8'd56;
  localparam logic [7:0] RST_ZERO_LEN  = 8'd24;

  // Frame bits other than data: opcode, lock bit and block address.
  localparam int unsigned HDR_BITS = 6;

  // Depth of the command queue between front and back.
  localparam int unsigned QDEPTH = 2;

  // Command kinds produced by the front.
  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_kind_t;

  // Sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_GAP  = 3'b010,
    PH_MARK = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  opcode;
    logic        lock_bit;
    logic [31:0] data_word;
    logic [2:0]  block_address;
  } in_item_t;

  typedef struct packed {
    logic carrier_en;
    logic busy_res;
    logic frame_done;
    logic start_rejected;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [1:0]  opcode;
    logic        lock_bit;
    logic [31:0] data_word;
    logic [2:0]  block_address;
  } cmd_t;

endpackage

### rtl/rfid_gap_write_encoder.sv
// Top level of the fixed bit length gap write encoder.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    rgwe_pkg::in_item_t
//   out_     output     out_valid/out_ready  rgwe_pkg::out_item_t
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item is accepted and one result is produced per cycle while the result
// side does not stall; the sequencer updates its counter and shift register
// once per item. An accepted item waits in the front register, then in a
// queue entry, and its result is then held in the result register.
// Reset is synchronous and active low and needs no clearing pass.
// While the result side stalls, the queue and front register take three more
// items before in_ready drops; input resumes in the cycle after output does.
module rfid_gap_write_encoder #(
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rgwe_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rgwe_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rgwe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  logic           push;
  logic           push_ready;
  rgwe_pkg::cmd_t front_cmd;
  logic           q_valid;
  logic           pop;
  rgwe_pkg::cmd_t q_cmd;

  // Accept and classify items.
  rgwe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .push_o       (push),
    .push_ready_i (push_ready),
    .cmd_o        (front_cmd)
  );

  // Decouple front and back.
  rgwe_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .push_ready_o (push_ready),
    .cmd_i        (front_cmd),
    .q_valid_o    (q_valid),
    .pop_i        (pop),
    .cmd_o        (q_cmd)
  );

  // Run the gap coding sequencer.
  rgwe_back #(
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid_i (q_valid),
    .cmd_i     (q_cmd),
    .pop_o     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

### rtl/rgwe_front.sv
// Front stage: accepts input items and classifies them into commands.
`include "assert_macros.svh"

module rgwe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rgwe_pkg::in_item_t in_data,
  output logic              push_o,
  input  logic              push_ready_i,
  output rgwe_pkg::cmd_t    cmd_o
);

  logic           valid_r;
  rgwe_pkg::cmd_t cmd_r;
  rgwe_pkg::cmd_t cmd_nxt;

  // The stage takes a new item whenever it is empty or its held command moves on.
  assign in_ready = !valid_r || push_ready_i;
  assign push_o   = valid_r;
  assign cmd_o    = cmd_r;

  // Decode the mode into a command kind.
  always_comb begin
    cmd_nxt.opcode        = in_data.opcode;
    cmd_nxt.lock_bit      = in_data.lock_bit;
    cmd_nxt.data_word     = in_data.data_word;
    cmd_nxt.block_address = in_data.block_address;
    unique case (in_data.mode)
      rgwe_pkg::MODE_TICK:  cmd_nxt.kind = rgwe_pkg::CMD_TICK;
      rgwe_pkg::MODE_WRITE: cmd_nxt.kind = rgwe_pkg::CMD_WRITE;
      rgwe_pkg::MODE_READ:  cmd_nxt.kind = rgwe_pkg::CMD_READ;
      default:              cmd_nxt.kind = rgwe_pkg::CMD_NOP;
    endcase
  end

  // Stage valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

  // A held command that cannot move on stays put.
  `RGWE_ASSERT_NXT(a_front_hold, valid_r && !push_ready_i, valid_r && $stable(cmd_r),
                   "front command lost while queue full")

endmodule

### rtl/rgwe_queue.sv
// Short command queue between the front and the back.
`include "assert_macros.svh"

module rgwe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  output logic           push_ready_o,
  input  rgwe_pkg::cmd_t cmd_i,
  output logic           q_valid_o,
  input  logic           pop_i,
  output rgwe_pkg::cmd_t cmd_o
);

  localparam int unsigned PTR_W = (rgwe_pkg::QDEPTH > 1) ? $clog2(rgwe_pkg::QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(rgwe_pkg::QDEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rgwe_pkg::QDEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(rgwe_pkg::QDEPTH);

  rgwe_pkg::cmd_t   entry_r [rgwe_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = (count_r != FULL_CNT);
  assign q_valid_o    = (count_r != '0);
  assign cmd_o        = entry_r[rd_ptr_r];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && q_valid_o;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // The fill count never passes the depth.
  `RGWE_ASSERT(a_queue_cnt, count_r <= FULL_CNT, "queue count beyond depth")
  // A pop with no push lowers the count by one.
  `RGWE_ASSERT_NXT(a_queue_pop, do_pop && !do_push, count_r == $past(count_r) - CNT_W'(1),
                   "queue count did not drop on pop")

endmodule

### rtl/rgwe_back.sv
// Back stage: gap coding sequencer, configuration registers and result register.
`include "assert_macros.svh"

module rgwe_back #(
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid_i,
  input  rgwe_pkg::cmd_t                    cmd_i,
  output logic                              pop_o,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rgwe_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgwe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                        cfg_data
);

  localparam int unsigned FRAME_W = DATA_BITS + rgwe_pkg::HDR_BITS;
  localparam int unsigned CNT_W   = $clog2(FRAME_W + 1);

  logic [7:0]          lead_gap_r;
  logic [7:0]          write_gap_r;
  logic [7:0]          one_len_r;
  logic [7:0]          zero_len_r;

  rgwe_pkg::phase_t    phase_r;
  rgwe_pkg::phase_t    phase_nxt;
  logic [7:0]          tick_r;
  logic [7:0]          tick_nxt;
  logic [FRAME_W-1:0]  frame_r;
  logic [FRAME_W-1:0]  frame_nxt;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W-1:0]    rem_nxt;

  logic                out_valid_r;
  rgwe_pkg::out_item_t out_data_r;
  rgwe_pkg::out_item_t res_nxt;
  logic                busy;

  // Take the next command when the result register is free or being emptied.
  assign pop_o     = q_valid_i && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign busy      = (phase_r != rgwe_pkg::PH_IDLE);

  // Configuration registers; writes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_gap_r  <= rgwe_pkg::RST_START_GAP;
      write_gap_r <= rgwe_pkg::RST_WRITE_GAP;
      one_len_r   <= rgwe_pkg::RST_ONE_LEN;
      zero_len_r  <= rgwe_pkg::RST_ZERO_LEN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rgwe_pkg::CFG_START_GAP: lead_gap_r  <= cfg_data;
        rgwe_pkg::CFG_WRITE_GAP: write_gap_r <= cfg_data;
        rgwe_pkg::CFG_ONE_LEN:   one_len_r   <= cfg_data;
        rgwe_pkg::CFG_ZERO_LEN:  zero_len_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next sequencer state and the result of one command.
  always_comb begin
    phase_nxt              = phase_r;
    tick_nxt               = tick_r;
    frame_nxt              = frame_r;
    rem_nxt                = rem_r;
    res_nxt.carrier_en     = 1'b1;
    res_nxt.frame_done     = 1'b0;
    res_nxt.start_rejected = 1'b0;
    unique case (cmd_i.kind)
      rgwe_pkg::CMD_WRITE, rgwe_pkg::CMD_READ: begin
        if (busy) begin
          res_nxt.start_rejected = 1'b1;
          res_nxt.carrier_en     = (phase_r == rgwe_pkg::PH_MARK);
        end else begin
          // Frame is left aligned so the next bit is always the top one.
          if (cmd_i.kind == rgwe_pkg::CMD_WRITE) begin
            frame_nxt = {cmd_i.opcode, cmd_i.lock_bit, cmd_i.data_word[DATA_BITS-1:0],
                         cmd_i.block_address};
            rem_nxt   = CNT_W'(FRAME_W);
          end else begin
            frame_nxt = {cmd_i.opcode, cmd_i.lock_bit, cmd_i.block_address,
                         {DATA_BITS{1'b0}}};
            rem_nxt   = CNT_W'(rgwe_pkg::HDR_BITS);
          end
          tick_nxt           = lead_gap_r;
          phase_nxt          = rgwe_pkg::PH_GAP;
          res_nxt.carrier_en = 1'b0;
        end
      end
      rgwe_pkg::CMD_TICK: begin
        unique case (phase_r)
          rgwe_pkg::PH_GAP: begin
            res_nxt.carrier_en = 1'b0;
            if (tick_r <= 8'd1) begin
              if (rem_r == '0) begin
                phase_nxt          = rgwe_pkg::PH_IDLE;
                tick_nxt           = '0;
                res_nxt.frame_done = 1'b1;
              end else begin
                rem_nxt   = rem_r - CNT_W'(1);
                tick_nxt  = frame_r[FRAME_W-1] ? one_len_r : zero_len_r;
                frame_nxt = {frame_r[FRAME_W-2:0], 1'b0};
                phase_nxt = rgwe_pkg::PH_MARK;
              end
            end else begin
              tick_nxt = tick_r - 8'd1;
            end
          end
          rgwe_pkg::PH_MARK: begin
            res_nxt.carrier_en = 1'b1;
            if (tick_r <= 8'd1) begin
              tick_nxt  = write_gap_r;
              phase_nxt = rgwe_pkg::PH_GAP;
            end else begin
              tick_nxt = tick_r - 8'd1;
            end
          end
          rgwe_pkg::PH_IDLE: begin
            res_nxt.carrier_en = 1'b1;
          end
          default: begin
            phase_nxt = rgwe_pkg::PH_IDLE;
          end
        endcase
      end
      default: begin
        // A mode without meaning changes no state; it reports the carrier level and busy flag.
        res_nxt.carrier_en = busy ? (phase_r == rgwe_pkg::PH_MARK) : 1'b1;
      end
    endcase
    res_nxt.busy_res = (phase_nxt != rgwe_pkg::PH_IDLE);
  end

  // Sequencer state advances once per command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rgwe_pkg::PH_IDLE;
      tick_r  <= '0;
      frame_r <= '0;
      rem_r   <= '0;
    end else if (pop_o) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      frame_r <= frame_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_o) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (pop_o) begin
      out_data_r <= res_nxt;
    end
  end

  // A finished frame leaves the sequencer idle.
  `RGWE_ASSERT_NXT(a_back_done, pop_o && res_nxt.frame_done, phase_r == rgwe_pkg::PH_IDLE,
                   "frame done without returning to idle")
  // The busy flag of a new result follows the phase it leaves behind.
  `RGWE_ASSERT_NXT(a_back_busy, pop_o, out_data_r.busy_res == (phase_r != rgwe_pkg::PH_IDLE),
                   "busy flag disagrees with phase")
  // The bit count never exceeds the frame length.
  `RGWE_ASSERT(a_back_rem, rem_r <= CNT_W'(FRAME_W), "bit count beyond frame length")

endmodule
